FILE: hdl/keypad_entry_seven_segment_scanner_assert.svh
// Assertion macros used by the kess_back scanner module.
`ifndef KEYPAD_ENTRY_SEVEN_SEGMENT_SCANNER_ASSERT_SVH
`define KEYPAD_ENTRY_SEVEN_SEGMENT_SCANNER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KESS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define KESS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/kess_pkg.sv
package kess_pkg;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_KEY  = 1'b1;

  localparam logic [7:0] DIVIDER_RESET = 8'd5;

  localparam logic [7:0] SEG_TABLE [16] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
    8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71
  };

  typedef struct packed {
    logic       is_key;
    logic [7:0] pattern;
  } cmd_t;

endpackage

FILE: hdl/kess_front.sv
module kess_front (
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          operation,
  input  logic [3:0]    key_code,
  output logic          push_valid,
  input  logic          push_ready,
  output kess_pkg::cmd_t push_cmd
);
  import kess_pkg::*;

  // classify the word and look up its pattern
  always_comb begin
    push_cmd.is_key  = (operation == OP_KEY);
    push_cmd.pattern = SEG_TABLE[key_code];
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

FILE: hdl/kess_fifo.sv
module kess_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  kess_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output kess_pkg::cmd_t pop_cmd
);
  import kess_pkg::*;

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/kess_back.sv
module kess_back #(
  parameter int NUM_DIGITS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_wdata,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  kess_pkg::cmd_t pop_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     segments,
  output logic [2:0]     digit_select
);
  import kess_pkg::*;

  localparam int SEL_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  logic [7:0]       scan_divider;
  logic [7:0]       digit_store [NUM_DIGITS];
  logic [7:0]       tick_count;
  logic [SEL_W-1:0] scan_slot;
  logic [SEL_W-1:0] select_latch;
  logic [7:0]       segment_latch;

  logic [7:0]       limit;
  logic [7:0]       tick_count_next;
  logic             step;
  logic             pop;
  logic [SEL_W-1:0] scan_slot_next;
  logic [SEL_W-1:0] select_latch_next;
  logic [7:0]       segment_latch_next;
  logic [SEL_W+2:0] select_wide;
  logic [SEL_W:0]   pair_sum;

  assign pop       = pop_valid && (!out_valid || out_ready);
  assign pop_ready = !out_valid || out_ready;

  always_comb begin
    limit           = (scan_divider == 8'd0) ? 8'd1 : scan_divider;
    tick_count_next = tick_count + 8'd1;
    step            = (tick_count_next >= limit);
    if (select_latch == '0) begin
      select_latch_next = SEL_W'(NUM_DIGITS - 1);
    end else begin
      select_latch_next = select_latch - SEL_W'(1);
    end
    if (scan_slot == SEL_W'(NUM_DIGITS - 1)) begin
      scan_slot_next = '0;
    end else begin
      scan_slot_next = scan_slot + SEL_W'(1);
    end
    segment_latch_next = digit_store[scan_slot];
    select_wide        = {3'b000, select_latch_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_divider <= DIVIDER_RESET;
    end else if (cfg_we) begin
      scan_divider <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digit_store[i] <= 8'h00;
      end
      tick_count    <= 8'd0;
      scan_slot     <= '0;
      select_latch  <= '0;
      segment_latch <= 8'h00;
      out_valid     <= 1'b0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop && pop_cmd.is_key) begin
        // shift older patterns up, drop the top slot
        for (int i = NUM_DIGITS - 1; i > 0; i--) begin
          digit_store[i] <= digit_store[i-1];
        end
        digit_store[0] <= pop_cmd.pattern;
      end else if (pop) begin
        if (step) begin
          tick_count    <= 8'd0;
          select_latch  <= select_latch_next;
          scan_slot     <= scan_slot_next;
          segment_latch <= segment_latch_next;
        end else begin
          tick_count <= tick_count_next;
        end
      end
    end
  end

  // result word shows the latches after the item is applied
  always_ff @(posedge clk) begin
    if (pop) begin
      if (!pop_cmd.is_key && step) begin
        segments     <= segment_latch_next;
        digit_select <= select_wide[2:0];
      end else begin
        segments     <= segment_latch;
        digit_select <= 3'({3'b000, select_latch});
      end
    end
  end

  assign pair_sum = {1'b0, select_latch} + {1'b0, scan_slot};

`include "keypad_entry_seven_segment_scanner_assert.svh"

  `KESS_ASSERT_NOW(a_slot_select_paired, 1'b1, (pair_sum == '0) || (pair_sum == (SEL_W+1)'(NUM_DIGITS)), "scan slot and digit select out of step")
  `KESS_ASSERT_NEXT(a_key_enters_slot0, pop && pop_cmd.is_key, digit_store[0] == $past(pop_cmd.pattern), "key pattern missing from slot 0")
  `KESS_ASSERT_NEXT(a_key_holds_latch, pop && pop_cmd.is_key, $stable(segment_latch) && $stable(select_latch), "key press moved the scan")
  `KESS_ASSERT_NEXT(a_result_matches_latch, pop, (segments == segment_latch) && (out_valid == 1'b1), "result word differs from latch")

endmodule

FILE: hdl/keypad_entry_seven_segment_scanner.sv
// Eight-digit multiplexed display scanner with key entry. Each input word is
// a timer tick or a key press; each gives exactly one result word holding the
// segment latch and digit select after it is applied. A key press pushes its
// table pattern into slot 0; every scan_divider ticks (0 acts as 1) the next
// slot is latched and the select steps down, wrapping 7 to 0 back to 7. One
// word is taken per clock while the output is accepted: the input side feeds a
// two-entry queue, and the executor retires one queued word per cycle into a
// registered output, so each word passes through the queue entry and then the
// output register; throughput is one word a cycle while the output is taken.
module keypad_entry_seven_segment_scanner #(
  parameter int NUM_DIGITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       operation,
  input  logic [3:0] key_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] segments,
  output logic [2:0] digit_select
);
  import kess_pkg::*;

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  kess_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .key_code   (key_code),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  kess_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  kess_back #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_cmd      (pop_cmd),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .segments     (segments),
    .digit_select (digit_select)
  );

endmodule
